FILE: sv/binary_run_line_counter_top_assert.svh
// ----------------------------------------------------------------------------
// binary_run_line_counter_top_assert.svh
// Assertion macros shared by the run line counter RTL.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BINARY_RUN_LINE_COUNTER_TOP_ASSERT_SVH
`define BINARY_RUN_LINE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BRLC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brlc_pkg.sv
// ----------------------------------------------------------------------------
// brlc_pkg
// Types, constants and helpers of the binary run line counter.
// ----------------------------------------------------------------------------
`default_nettype none

package brlc_pkg;

    localparam int CFG_W     = 13;
    localparam int RUN_W     = 13;
    localparam int TOTAL_W   = 26;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_LINE_DEF   = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd4096;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd4096;
    localparam logic [CFG_W-1:0] RUN_LENGTH_RST   = 13'd20;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH   = 2'd2;

    typedef struct packed {
        logic pixel;
        logic frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic               horizontal_hit;
        logic               vertical_hit;
        logic [TOTAL_W-1:0] match_count;
        logic               frame_last;
    } result_item_t;

    // Per-item flags from the scan stage to the update stage
    typedef struct packed {
        logic pixel;
        logic col_zero;
        logic row_zero;
        logic clear_total;
        logic frame_last;
    } scan_info_t;

    function automatic logic [RUN_W-1:0] extend_run(input logic [RUN_W-1:0] prev,
                                                    input logic px);
        logic [RUN_W-1:0] res;
        if (!px)
            res = '0;
        else if (prev == RUN_MAX)
            res = RUN_MAX;
        else
            res = prev + RUN_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/binary_run_line_counter_top.sv
// Each accepted pixel item is registered in the update stage, and its result
//   item then in the output register, where out_valid marks it.
// Throughput: 1 item per cycle unless out_ready stalls the output; the column
//   store read and write-back each use one RAM port per cycle, with write-to-read forwarding.
// Reset: asynchronous active-low; clears position, runs, total and valids.
// The column store is not cleared; row zero ignores the value read from it.
// ----------------------------------------------------------------------------
// binary_run_line_counter_top
// Counts horizontal and vertical runs of ones in a raster binary image.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_run_line_counter_top_assert.svh"

module binary_run_line_counter_top
    import brlc_pkg::*;
#(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pixel_item_t          in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_item_t              out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_LINE);

    logic             accept;
    logic [CW-1:0]    col;
    scan_info_t       info;
    logic [CFG_W-1:0] run_length;
    logic [RUN_W-1:0] rd_data;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [RUN_W-1:0] wr_data;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    brlc_scan #(
        .MAX_LINE   (MAX_LINE),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .item       (in_data),
        .col        (col),
        .info       (info),
        .run_length (run_length)
    );

    brlc_ram #(
        .WIDTH (RUN_W),
        .DEPTH (MAX_LINE)
    ) u_column_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data)
    );

    brlc_update #(
        .MAX_LINE (MAX_LINE)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .info       (info),
        .col        (col),
        .rd_data    (rd_data),
        .run_length (run_length),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    `BRLC_ASSERT_NOW(a_hit_counted,
        out_valid && (out_data.horizontal_hit || out_data.vertical_hit),
        out_data.match_count != '0, "hit reported with zero total")
    `BRLC_ASSERT_NEXT(a_stall_blocks_input,
        out_valid && !out_ready && wr_en == 1'b0 && !in_ready,
        !in_ready || out_ready, "input taken while pipeline full")
    `BRLC_ASSERT_NEXT(a_write_makes_result, wr_en, out_valid, "write-back without result item")

endmodule

`default_nettype wire

FILE: sv/brlc_ram.sv
// ----------------------------------------------------------------------------
// brlc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/brlc_scan.sv
// ----------------------------------------------------------------------------
// brlc_scan
// Configuration registers and raster position tracking; issues the column
// store read for each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_scan
    import brlc_pkg::*;
#(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,
    input  wire logic                        accept,
    input  wire pixel_item_t                 item,
    output logic      [$clog2(MAX_LINE)-1:0] col,
    output scan_info_t                       info,
    output logic      [CFG_W-1:0]            run_length
);

    localparam int CW  = $clog2(MAX_LINE);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int LWM = $clog2(MAX_LINE + 1);
    localparam int HWM = $clog2(MAX_HEIGHT + 1);
    localparam int LW  = (CFG_W > LWM) ? CFG_W : LWM;
    localparam int HW  = (CFG_W > HWM) ? CFG_W : HWM;

    logic [CFG_W-1:0] line_width_reg, line_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CFG_W-1:0] run_length_reg, run_length_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic             wrap_reg, wrap_next;

    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [LW-1:0] width_raw, width_eff;
    logic [HW-1:0] height_raw, height_eff;
    logic          last_col, last_row;

    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        run_length_next   = run_length_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_next   = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                REG_RUN_LENGTH:   run_length_next   = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        // Clamp dimensions to [1, max]
        width_raw = LW'(line_width_reg);
        if (width_raw == '0)
            width_eff = LW'(1);
        else if (width_raw > LW'(MAX_LINE))
            width_eff = LW'(MAX_LINE);
        else
            width_eff = width_raw;

        height_raw = HW'(frame_height_reg);
        if (height_raw == '0)
            height_eff = HW'(1);
        else if (height_raw > HW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = height_raw;

        cur_col = item.frame_start ? '0 : col_reg;
        cur_row = item.frame_start ? '0 : row_reg;

        last_col = (LW'(cur_col) + LW'(1)) >= width_eff;
        last_row = (HW'(cur_row) + HW'(1)) >= height_eff;

        col_next  = col_reg;
        row_next  = row_reg;
        wrap_next = wrap_reg;
        if (accept)
        begin
            wrap_next = last_col && last_row;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : cur_row + RW'(1);
            end
            else
            begin
                col_next = cur_col + CW'(1);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            run_length_reg   <= RUN_LENGTH_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            wrap_reg         <= 1'b0;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            run_length_reg   <= run_length_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            wrap_reg         <= wrap_next;
        end
    end

    assign col              = cur_col;
    assign info.pixel       = item.pixel;
    assign info.col_zero    = (cur_col == '0);
    assign info.row_zero    = (cur_row == '0);
    // Total restarts on an explicit frame start or after the last pixel
    assign info.clear_total = item.frame_start || wrap_reg;
    assign info.frame_last  = last_col && last_row;
    assign run_length       = run_length_reg;

endmodule

`default_nettype wire

FILE: sv/brlc_update.sv
// ----------------------------------------------------------------------------
// brlc_update
// Read-modify-write stage: extends row and column runs, flags hits, keeps
// the frame total, writes the column run back and holds the output item.
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_update
    import brlc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire scan_info_t                  info,
    input  wire logic [$clog2(MAX_LINE)-1:0] col,
    input  wire logic [RUN_W-1:0]            rd_data,
    input  wire logic [CFG_W-1:0]            run_length,
    output logic                             wr_en,
    output logic      [$clog2(MAX_LINE)-1:0] wr_addr,
    output logic      [RUN_W-1:0]            wr_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output result_item_t                     out_data
);

    localparam int CW = $clog2(MAX_LINE);

    logic             s1_valid_reg, s1_valid_next;
    scan_info_t       s1_info_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             fwd_hit_reg;
    logic [RUN_W-1:0] fwd_data_reg;
    logic [RUN_W-1:0] row_run_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic             out_valid_reg, out_valid_next;
    result_item_t     out_data_reg;

    logic             accept, s1_advance;
    logic [RUN_W-1:0] above, left, hrun, vrun;
    logic             hhit, vhit;
    logic [TOTAL_W-1:0] base;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sum_sat;
    result_item_t     result;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        // Take the column run just written when the RAM read missed it
        above = fwd_hit_reg ? fwd_data_reg : rd_data;
        if (s1_info_reg.row_zero)
            above = '0;
        left = s1_info_reg.col_zero ? '0 : row_run_reg;

        hrun = extend_run(left, s1_info_reg.pixel);
        vrun = extend_run(above, s1_info_reg.pixel);

        hhit = (run_length != '0) && (hrun >= run_length);
        vhit = (run_length != '0) && (vrun >= run_length);

        base    = s1_info_reg.clear_total ? '0 : total_reg;
        sum     = {1'b0, base} + (TOTAL_W+1)'(hhit) + (TOTAL_W+1)'(vhit);
        sum_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

        result.horizontal_hit = hhit;
        result.vertical_hit   = vhit;
        result.match_count    = sum_sat;
        result.frame_last     = s1_info_reg.frame_last;

        s1_valid_next  = accept || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            row_run_reg   <= '0;
            total_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= s1_advance && (s1_col_reg == col);
            end
            if (s1_advance)
            begin
                row_run_reg <= hrun;
                total_reg   <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg  <= info;
            s1_col_reg   <= col;
            fwd_data_reg <= vrun;
        end
        if (s1_advance)
        begin
            out_data_reg <= result;
        end
    end

    assign wr_en     = s1_advance;
    assign wr_addr   = s1_col_reg;
    assign wr_data   = vrun;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/sv/binary_run_line_counter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_run_line_counter_top_test
// Streams binary pixel items into the run line counter, tracks row and
// column streaks in a scoreboard of its own and compares every result item
// field by field, under several frame shapes and idle patterns.
// ----------------------------------------------------------------------------

module binary_run_line_counter_top_test;
    import brlc_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1750;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Scoreboard: streak state per row and column, expected results in order
    class segment_tracker;
        logic [CFG_W-1:0]   line_width;
        logic [CFG_W-1:0]   frame_height;
        logic [CFG_W-1:0]   run_length;
        logic [RUN_W-1:0]   row_run;
        logic [RUN_W-1:0]   column_runs [MAX_LINE_DEF];
        int unsigned        col_pos;
        int unsigned        row_pos;
        logic [TOTAL_W-1:0] total;
        result_item_t       expected_tallies [$];
        int unsigned        fail_count;

        function new();
            line_width   = LINE_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            run_length   = RUN_LENGTH_RST;
            row_run      = '0;
            col_pos      = 0;
            row_pos      = 0;
            total        = '0;
            fail_count   = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return 32'(v);
        endfunction

        function logic [RUN_W-1:0] streak_after(logic [RUN_W-1:0] prev, logic px);
            if (!px)
                return '0;
            if (prev == '1)
                return prev;
            return prev + RUN_W'(1);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_LINE_WIDTH:   line_width = value;
                REG_FRAME_HEIGHT: frame_height = value;
                REG_RUN_LENGTH:   run_length = value;
                default: ;
            endcase
        endfunction

        function void note_pixel(pixel_item_t item);
            int unsigned      w;
            int unsigned      h;
            logic             last_col;
            logic             last_row;
            logic [RUN_W-1:0] hrun;
            logic [RUN_W-1:0] vrun;
            logic             hhit;
            logic             vhit;
            logic [TOTAL_W:0] sum;
            result_item_t     exp_item;

            w = clamp_size(line_width, MAX_LINE_DEF);
            h = clamp_size(frame_height, MAX_HEIGHT_DEF);
            if (item.frame_start)
            begin
                col_pos = 0;
                row_pos = 0;
                total   = '0;
            end
            last_col = (col_pos + 1 >= w);
            last_row = (row_pos + 1 >= h);

            // Column zero has no streak to its left, row zero none above
            hrun = streak_after((col_pos == 0) ? '0 : row_run, item.pixel);
            vrun = streak_after((row_pos == 0) ? '0 : column_runs[col_pos], item.pixel);
            row_run = hrun;
            column_runs[col_pos] = vrun;

            hhit = (run_length != 0) && (hrun >= run_length);
            vhit = (run_length != 0) && (vrun >= run_length);
            sum  = {1'b0, total} + (TOTAL_W+1)'(hhit) + (TOTAL_W+1)'(vhit);
            total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];

            exp_item.horizontal_hit = hhit;
            exp_item.vertical_hit   = vhit;
            exp_item.match_count    = total;
            exp_item.frame_last     = last_col && last_row;
            expected_tallies.push_back(exp_item);

            if (last_col)
            begin
                col_pos = 0;
                if (last_row)
                begin
                    row_pos = 0;
                    total   = '0;
                end
                else
                    row_pos++;
            end
            else
                col_pos++;
        endfunction

        function void check_result(result_item_t got);
            result_item_t exp_item;

            if (expected_tallies.size() == 0)
            begin
                $error("result item with nothing expected: %p", got);
                fail_count++;
                return;
            end
            exp_item = expected_tallies.pop_front();
            if (got.horizontal_hit !== exp_item.horizontal_hit)
            begin
                $error("horizontal_hit: expected %0d, actual %0d",
                       exp_item.horizontal_hit, got.horizontal_hit);
                fail_count++;
            end
            if (got.vertical_hit !== exp_item.vertical_hit)
            begin
                $error("vertical_hit: expected %0d, actual %0d",
                       exp_item.vertical_hit, got.vertical_hit);
                fail_count++;
            end
            if (got.match_count !== exp_item.match_count)
            begin
                $error("match_count: expected %0d, actual %0d",
                       exp_item.match_count, got.match_count);
                fail_count++;
            end
            if (got.frame_last !== exp_item.frame_last)
            begin
                $error("frame_last: expected %0d, actual %0d",
                       exp_item.frame_last, got.frame_last);
                fail_count++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    pixel_item_t          in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 cfg_ready;
    result_item_t         out_data;

    segment_tracker tally = new();
    int unsigned    send_idle_pct = 21;
    int unsigned    recv_idle_pct = 82;
    int unsigned    stall_cycles  = 0;
    int unsigned    applied_width = 0;
    bit             force_frame_start = 1'b0;

    binary_run_line_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tally.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                tally.note_pixel(in_data);
            if (out_valid && out_ready)
                tally.check_result(out_data);

            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
                (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Hold valid across back-to-back items; drop it only for a gap
    task automatic send_pixel(input logic px, input logic fs);
        int unsigned gap;
        pixel_item_t item;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        item.pixel       = px;
        item.frame_start = fs | force_frame_start;
        force_frame_start = 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tally.expected_tallies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] w,
                                  input logic [CFG_W-1:0] h,
                                  input logic [CFG_W-1:0] r);
        int unsigned eff_width;

        drain_results();
        repeat (4) @(posedge clk);
        // A wider row would read column entries never written: restart the frame
        eff_width = tally.clamp_size(w, MAX_LINE_DEF);
        if (eff_width > applied_width)
            force_frame_start = 1'b1;
        applied_width = eff_width;
        write_register(REG_LINE_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
        write_register(REG_RUN_LENGTH, r);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned      mode;
        int unsigned      sent;
        int unsigned      n;
        int unsigned      ones_pct;
        int unsigned      kind;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame of ones, then two more pixels that open the next frame
        apply_settings(13'd3, 13'd3, 13'd3);
        for (int i = 0; i < 11; i++)
            send_pixel(1'b1, i == 0);
        // zero sizes act as one: every pixel is a whole frame
        apply_settings(13'd0, 13'd0, 13'd1);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b1);
        send_pixel(1'b1, 1'b0);
        // oversized frame, run length zero never hits
        apply_settings(13'd8191, 13'd8191, 13'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(1'b1, 1'b0);
        // shrink below the current position in mid-frame
        apply_settings(13'd2, 13'd0, 13'd2);
        for (int i = 0; i < 3; i++)
            send_pixel(1'b1, 1'b0);

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                kind = $urandom_range(9);
                if (kind == 0)
                begin
                    // narrow and tall: long vertical streaks
                    w = 13'($urandom_range(0, 2));
                    h = 13'($urandom_range(24, 8191));
                    r = 13'($urandom_range(4, 24));
                    ones_pct = 97;
                    n = $urandom_range(40, 90);
                end
                else if (kind == 1)
                begin
                    w = 13'($urandom_range(64, 8191));
                    h = 13'($urandom_range(0, 8191));
                    r = 13'($urandom_range(1, 40));
                    ones_pct = 90;
                    n = $urandom_range(30, 80);
                end
                else
                begin
                    w = 13'($urandom_range(0, 10));
                    h = 13'($urandom_range(0, 8));
                    r = ($urandom_range(19) == 0) ? 13'd8191 : 13'($urandom_range(0, 6));
                    ones_pct = $urandom_range(30, 100);
                    n = $urandom_range(10, 60);
                end
                apply_settings(w, h, r);
                for (int i = 0; i < n; i++)
                    send_pixel($urandom_range(99) < ones_pct,
                               (i == 0) ? ($urandom_range(3) == 0) : ($urandom_range(99) == 0));
                sent += n;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (tally.fail_count == 0 && tally.expected_tallies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/brlc_pkg.sv
sv/brlc_ram.sv
sv/brlc_scan.sv
sv/brlc_update.sv
sv/binary_run_line_counter_top.sv
tb/sv/binary_run_line_counter_top_test.sv
